// File: hdl/modbus_rtu_master_framer_assert.svh
// Assertion macros shared by the Modbus RTU framer modules.
// Include with the bare file name; no other dependencies.
`ifndef MODBUS_RTU_MASTER_FRAMER_ASSERT_SVH
`define MODBUS_RTU_MASTER_FRAMER_ASSERT_SVH

// Clocked check, disabled while the synchronous reset is asserted.
`define MBRTU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define MBRTU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/mbrtu_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU framer.
// No dependencies.
package mbrtu_pkg;

  // Receive frame limit and counter width
  localparam int unsigned MAX_FRAME = 256;
  localparam int unsigned CNT_W     = 9;

  // CRC-16/Modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Function codes
  localparam logic [7:0] FN_READ  = 8'h03;
  localparam logic [7:0] FN_WRITE = 8'h06;

  // Request mode codes (the fourth code is ignored)
  localparam logic [1:0] MODE_RX    = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // Verdict status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BAD   = 2'd1;
  localparam logic [1:0] STAT_SHORT = 2'd2;

  // Configuration port: byte address 4*index
  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-3:0] REG_SLAVE_ID = '0;

  // Command queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef struct packed {
    logic             is_verdict;
    logic [7:0]       sid;
    logic [7:0]       fn;
    logic [15:0]      addr;
    logic [15:0]      word;
    logic [1:0]       status;
    logic [CNT_W-1:0] length;
    logic [15:0]      rcrc;
    logic [15:0]      ccrc;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One result item as held in the output register
  typedef struct packed {
    logic [7:0]       out_byte;
    logic             out_last;
    logic             is_verdict;
    logic [1:0]       frame_status;
    logic [CNT_W-1:0] frame_length;
    logic [15:0]      resp_crc;
    logic [15:0]      computed_crc;
  } res_t;

  // Reflected CRC-16 update by one byte, eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/mbrtu_if.sv
// Valid/ready channel interfaces for the framer's input and result streams.
// Depends on mbrtu_pkg.
interface mbrtu_in_if;
  import mbrtu_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  in_byte;
  logic        in_last;
  logic [15:0] reg_address;
  logic [15:0] word_value;

  modport source(output valid, mode, in_byte, in_last, reg_address, word_value,
                 input ready);
  modport sink(input valid, mode, in_byte, in_last, reg_address, word_value,
               output ready);
endinterface

interface mbrtu_out_if;
  import mbrtu_pkg::*;
  logic             valid;
  logic             ready;
  logic [7:0]       out_byte;
  logic             out_last;
  logic             is_verdict;
  logic [1:0]       frame_status;
  logic [CNT_W-1:0] frame_length;
  logic [15:0]      resp_crc;
  logic [15:0]      computed_crc;

  modport source(output valid, out_byte, out_last, is_verdict, frame_status,
                 frame_length, resp_crc, computed_crc, input ready);
  modport sink(input valid, out_byte, out_last, is_verdict, frame_status,
               frame_length, resp_crc, computed_crc, output ready);
endinterface

// File: hdl/mbrtu_front.sv
// Front end: accepts input items, runs the receive CRC window and queues commands.
// Depends on mbrtu_pkg, mbrtu_if and the assertion macro header.
`include "modbus_rtu_master_framer_assert.svh"

module mbrtu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         slave_id,
  mbrtu_in_if.sink           in_ch,
  input  mbrtu_pkg::q_stat_t q_stat,
  output logic               q_push,
  output mbrtu_pkg::q_entry_t q_din
);
  import mbrtu_pkg::*;

  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      win_r, win_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       fn_r, fn_nxt;

  logic             acc;
  logic             in_range;
  logic [15:0]      crc_upd, win_upd;
  logic [CNT_W-1:0] cnt_upd;
  logic [7:0]       fn_upd;

  // A request needs a queue slot; take items whenever one is free
  assign in_ch.ready = !q_stat.full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign in_range    = cnt_r < CNT_W'(MAX_FRAME);

  // Receive window: CRC trails the newest two bytes
  always_comb begin
    crc_upd = crc_r;
    win_upd = win_r;
    fn_upd  = fn_r;
    cnt_upd = cnt_r;
    if (in_range) begin
      if (cnt_r >= CNT_W'(2)) begin
        crc_upd = crc_byte(crc_r, win_r[7:0]);
      end
      win_upd = {in_ch.in_byte, win_r[15:8]};
      if (cnt_r == CNT_W'(1)) begin
        fn_upd = in_ch.in_byte;
      end
      cnt_upd = cnt_r + CNT_W'(1);
    end
  end

  // Classify the item and build the queue entry
  always_comb begin
    crc_nxt = crc_r;
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    fn_nxt  = fn_r;
    q_push  = 1'b0;
    q_din   = '0;
    q_din.sid  = slave_id;
    q_din.addr = in_ch.reg_address;
    q_din.word = in_ch.word_value;
    q_din.fn   = (in_ch.mode == MODE_READ) ? FN_READ : FN_WRITE;
    if (acc) begin
      case (in_ch.mode)
        MODE_RX: begin
          if (in_ch.in_last) begin
            // verdict, then receive state back to reset values
            q_push           = 1'b1;
            q_din.is_verdict = 1'b1;
            q_din.length     = cnt_upd;
            if (cnt_upd <= CNT_W'(2)) begin
              q_din.status = STAT_SHORT;
            end else begin
              q_din.status = (win_upd == crc_upd && fn_upd == FN_READ) ? STAT_OK : STAT_BAD;
              q_din.rcrc   = win_upd;
              q_din.ccrc   = crc_upd;
            end
            crc_nxt = CRC_INIT;
            win_nxt = '0;
            cnt_nxt = '0;
            fn_nxt  = '0;
          end else begin
            crc_nxt = crc_upd;
            win_nxt = win_upd;
            cnt_nxt = cnt_upd;
            fn_nxt  = fn_upd;
          end
        end
        MODE_READ, MODE_WRITE: begin
          q_push = 1'b1;
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      win_r <= '0;
      cnt_r <= '0;
      fn_r  <= '0;
    end else begin
      crc_r <= crc_nxt;
      win_r <= win_nxt;
      cnt_r <= cnt_nxt;
      fn_r  <= fn_nxt;
    end
  end

  `MBRTU_ASSERT(a_cnt_limit, clk, rst_n, cnt_r <= CNT_W'(MAX_FRAME), "byte count above frame limit")
  `MBRTU_ASSERT(a_last_clears, clk, rst_n, (acc && in_ch.mode == MODE_RX && in_ch.in_last) |=> (cnt_r == '0 && crc_r == CRC_INIT), "receive state not cleared after last byte")

endmodule

// File: hdl/mbrtu_fifo.sv
// Short command queue between the front end and the result sequencer.
// Depends on mbrtu_pkg and the assertion macro header.
`include "modbus_rtu_master_framer_assert.svh"

module mbrtu_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mbrtu_pkg::q_entry_t din,
  input  logic                pop,
  output mbrtu_pkg::q_entry_t head,
  output mbrtu_pkg::q_stat_t  stat
);
  import mbrtu_pkg::*;

  q_entry_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt;
  logic [FIFO_AW-1:0] rd_r, rd_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign stat.full  = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign head       = mem_r[rd_r];

  // Pointer and fill count
  always_comb begin
    wr_nxt  = push ? wr_r + FIFO_AW'(1) : wr_r;
    rd_nxt  = pop ? rd_r + FIFO_AW'(1) : rd_r;
    cnt_nxt = cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  `MBRTU_ASSERT(a_no_overflow, clk, rst_n, push |-> (!stat.full || pop), "push into full queue")
  `MBRTU_ASSERT(a_no_underflow, clk, rst_n, pop |-> !stat.empty, "pop from empty queue")

endmodule

// File: hdl/mbrtu_back.sv
// Result sequencer: serializes request frames with their CRC and forwards verdicts.
// Depends on mbrtu_pkg and mbrtu_if.
module mbrtu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mbrtu_pkg::q_entry_t head,
  input  mbrtu_pkg::q_stat_t  q_stat,
  output logic                q_pop,
  mbrtu_out_if.source         out_ch
);
  import mbrtu_pkg::*;

  typedef enum logic {ST_IDLE, ST_SEND} state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  fn_r, fn_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] word_r, word_nxt;
  logic        ov_r, ov_nxt;
  res_t        res_r, res_nxt;

  logic        load;
  logic [7:0]  cur_byte;
  logic [15:0] crc_src, crc_new;
  logic [7:0]  crc_din;

  // Output slot free this cycle
  assign load = !ov_r || out_ch.ready;

  // Byte of the request frame at the current position
  always_comb begin
    case (idx_r)
      3'd1:    cur_byte = fn_r;
      3'd2:    cur_byte = addr_r[15:8];
      3'd3:    cur_byte = addr_r[7:0];
      3'd4:    cur_byte = word_r[15:8];
      3'd5:    cur_byte = word_r[7:0];
      3'd6:    cur_byte = crc_r[7:0];
      3'd7:    cur_byte = crc_r[15:8];
      default: cur_byte = 8'h00;
    endcase
  end

  // One shared CRC byte update: first byte comes from the queue head
  assign crc_src = (state_r == ST_SEND) ? crc_r : CRC_INIT;
  assign crc_din = (state_r == ST_SEND) ? cur_byte : head.sid;
  assign crc_new = crc_byte(crc_src, crc_din);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    fn_nxt    = fn_r;
    addr_nxt  = addr_r;
    word_nxt  = word_r;
    ov_nxt    = ov_r;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    if (load) begin
      case (state_r)
        ST_SEND: begin
          ov_nxt           = 1'b1;
          res_nxt          = '0;
          res_nxt.out_byte = cur_byte;
          res_nxt.out_last = (idx_r == 3'd7);
          if (idx_r < 3'd6) begin
            crc_nxt = crc_new;
          end
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            state_nxt = ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_stat.empty) begin
            q_pop   = 1'b1;
            ov_nxt  = 1'b1;
            res_nxt = '0;
            if (head.is_verdict) begin
              res_nxt.out_last     = 1'b1;
              res_nxt.is_verdict   = 1'b1;
              res_nxt.frame_status = head.status;
              res_nxt.frame_length = head.length;
              res_nxt.resp_crc     = head.rcrc;
              res_nxt.computed_crc = head.ccrc;
            end else begin
              // slave id goes out now, the rest follows from the latched request
              res_nxt.out_byte = head.sid;
              crc_nxt   = crc_new;
              fn_nxt    = head.fn;
              addr_nxt  = head.addr;
              word_nxt  = head.word;
              idx_nxt   = 3'd1;
              state_nxt = ST_SEND;
            end
          end else begin
            ov_nxt = 1'b0;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
    crc_r  <= crc_nxt;
    fn_r   <= fn_nxt;
    addr_r <= addr_nxt;
    word_r <= word_nxt;
    res_r  <= res_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.out_byte     = res_r.out_byte;
  assign out_ch.out_last     = res_r.out_last;
  assign out_ch.is_verdict   = res_r.is_verdict;
  assign out_ch.frame_status = res_r.frame_status;
  assign out_ch.frame_length = res_r.frame_length;
  assign out_ch.resp_crc     = res_r.resp_crc;
  assign out_ch.computed_crc = res_r.computed_crc;

endmodule

// File: hdl/modbus_rtu_master_framer.sv
// Modbus RTU master framer top level: config register, front end, queue, sequencer.
// Depends on mbrtu_pkg, mbrtu_if, mbrtu_front, mbrtu_fifo and mbrtu_back.
//
//   channel  | direction | handshake        | carries
//   ---------+-----------+------------------+-------------------------------------
//   in_ch    | sink      | valid/ready      | mode, byte, last, address, word
//   out_ch   | source    | valid/ready      | tx byte or response verdict
//   cfg_*    | APB slave | psel/penable     | slave_id at byte address 0
//
// Receive bytes are taken one per cycle while ready; the CRC window updates in the
// same cycle. A request yields eight output bytes from the sequencer, back to back
// unless output stalls, one CRC update per byte before the CRC; a verdict is one
// output item. A four-entry command queue lets input continue while output stalls;
// in_ch.ready drops only when that queue is full. Output is registered. Reset is
// synchronous, active low; slave_id resets to 1, no clearing pass.
module modbus_rtu_master_framer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mbrtu_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  mbrtu_in_if.sink                    in_ch,
  mbrtu_out_if.source                 out_ch
);
  import mbrtu_pkg::*;

  logic [7:0] slave_id_r, slave_id_nxt;
  logic       cfg_wr;
  logic       sel_sid;
  logic       q_push, q_pop;
  q_entry_t   q_din, q_head;
  q_stat_t    q_stat;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign sel_sid    = cfg_paddr[CFG_AW-1:2] == REG_SLAVE_ID;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = sel_sid ? {24'h000000, slave_id_r} : 32'h0;

  always_comb begin
    slave_id_nxt = slave_id_r;
    if (cfg_wr && sel_sid) begin
      slave_id_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_id_r <= 8'h01;
    end else begin
      slave_id_r <= slave_id_nxt;
    end
  end

  mbrtu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .slave_id (slave_id_r),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_din    (q_din)
  );

  mbrtu_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  mbrtu_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// File: bench/modbus_rtu_master_framer_test.sv
// Self-checking bench for modbus_rtu_master_framer: request framing with CRC-16 and
// response verdicts, checked against an in-bench model under random flow control.
// Depends on mbrtu_pkg, mbrtu_if and the framer RTL.
module modbus_rtu_master_framer_test;
  import mbrtu_pkg::*;

  localparam logic [15:0] CRC_SEED           = 16'hFFFF;
  localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;
  localparam logic [1:0]  MODE_UNUSED        = 2'd3;
  localparam logic [7:0]  FN_READ_EXCEPTION  = FN_READ | 8'h80;
  localparam logic [CFG_AW-1:0] SLAVE_ID_ADDR = {REG_SLAVE_ID, 2'b00};
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 3000;
  localparam int PHASE_ITEMS     = 12;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data;
    logic        last;
    logic [15:0] addr;
    logic [15:0] word;
  } framer_req_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mbrtu_in_if  in_ch();
  mbrtu_out_if out_ch();

  modbus_rtu_master_framer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Requests waiting to be sent, and tx bytes / verdicts waiting to come out
  framer_req_t request_q[$];
  res_t        tx_verdict_q[$];
  logic [7:0]  frame_bytes[$];

  int stim_count    = 0;
  int fail_count    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  bit in_taken      = 1'b0;

  // Model state: slave id register and the receive side
  logic [7:0]       model_slave_id;
  logic [15:0]      rx_crc;
  logic [15:0]      rx_window;
  logic [CNT_W-1:0] rx_count;
  logic [7:0]       rx_fn;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reflected CRC-16 over one byte, LSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    r = acc ^ {8'h00, data};
    repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? CRC_REFLECTED_POLY : 16'h0000);
    return r;
  endfunction

  function automatic void clear_rx_model();
    rx_crc    = CRC_SEED;
    rx_window = '0;
    rx_count  = '0;
    rx_fn     = '0;
  endfunction

  function automatic void log_failure(input string msg);
    if (fail_count < 10) begin
      $display("%s", msg);
    end
    fail_count++;
  endfunction

  function automatic string describe_result(input res_t r);
    return $sformatf("byte=%h last=%b verdict=%b status=%0d len=%0d rcrc=%h ccrc=%h",
                     r.out_byte, r.out_last, r.is_verdict, r.frame_status,
                     r.frame_length, r.resp_crc, r.computed_crc);
  endfunction

  // Expected tx bytes or verdict for one accepted request
  task automatic predict_tx_and_verdict(input framer_req_t r);
    res_t        res;
    logic [7:0]  frame [0:7];
    logic [15:0] crc;
    if (r.mode == MODE_READ || r.mode == MODE_WRITE) begin
      frame[0] = model_slave_id;
      frame[1] = (r.mode == MODE_READ) ? FN_READ : FN_WRITE;
      frame[2] = r.addr[15:8];
      frame[3] = r.addr[7:0];
      frame[4] = r.word[15:8];
      frame[5] = r.word[7:0];
      crc = CRC_SEED;
      for (int i = 0; i < 6; i++) crc = crc16_step(crc, frame[i]);
      frame[6] = crc[7:0];
      frame[7] = crc[15:8];
      for (int i = 0; i < 8; i++) begin
        res = '0;
        res.out_byte = frame[i];
        res.out_last = (i == 7);
        tx_verdict_q.push_back(res);
      end
    end else if (r.mode == MODE_RX) begin
      // bytes past the frame limit are dropped, but a final one still ends the frame
      if (rx_count < MAX_FRAME) begin
        if (rx_count >= 2) rx_crc = crc16_step(rx_crc, rx_window[7:0]);
        rx_window = {r.data, rx_window[15:8]};
        if (rx_count == 1) rx_fn = r.data;
        rx_count = rx_count + 1'b1;
      end
      if (r.last) begin
        res = '0;
        res.out_last     = 1'b1;
        res.is_verdict   = 1'b1;
        res.frame_length = rx_count;
        if (rx_count <= 2) begin
          res.frame_status = STAT_SHORT;
        end else begin
          res.resp_crc     = rx_window;
          res.computed_crc = rx_crc;
          res.frame_status = (rx_window == rx_crc && rx_fn == FN_READ) ? STAT_OK : STAT_BAD;
        end
        tx_verdict_q.push_back(res);
        clear_rx_model();
      end
    end
  endtask

  task automatic check_result();
    res_t  got;
    res_t  want;
    string diffs;
    got.out_byte     = out_ch.out_byte;
    got.out_last     = out_ch.out_last;
    got.is_verdict   = out_ch.is_verdict;
    got.frame_status = out_ch.frame_status;
    got.frame_length = out_ch.frame_length;
    got.resp_crc     = out_ch.resp_crc;
    got.computed_crc = out_ch.computed_crc;
    if (tx_verdict_q.size() == 0) begin
      log_failure({"unexpected result: ", describe_result(got)});
    end else begin
      want  = tx_verdict_q.pop_front();
      diffs = "";
      if (got.out_byte !== want.out_byte) diffs = {diffs, " out_byte"};
      if (got.out_last !== want.out_last) diffs = {diffs, " out_last"};
      if (got.is_verdict !== want.is_verdict) diffs = {diffs, " is_verdict"};
      if (got.frame_status !== want.frame_status) diffs = {diffs, " frame_status"};
      if (got.frame_length !== want.frame_length) diffs = {diffs, " frame_length"};
      if (got.resp_crc !== want.resp_crc) diffs = {diffs, " resp_crc"};
      if (got.computed_crc !== want.computed_crc) diffs = {diffs, " computed_crc"};
      if (diffs != "") begin
        log_failure($sformatf("mismatch in%s: expected %s, got %s", diffs,
                              describe_result(want), describe_result(got)));
      end
    end
  endtask

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      predict_tx_and_verdict(request_q.pop_front());
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      check_result();
    end
  end

  // Driver: hold a request until taken, then present the next one or idle
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= request_q[0].mode;
        in_ch.in_byte     <= request_q[0].data;
        in_ch.in_last     <= request_q[0].last;
        in_ch.reg_address <= request_q[0].addr;
        in_ch.word_value  <= request_q[0].word;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, plus long hold-offs on demand
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: too long without any handshake
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("modbus_rtu_master_framer_test failed");
    $finish;
  end

  task automatic apb_transfer(input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= SLAVE_ID_ADDR;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Write slave_id, read it back
  task automatic program_slave_id(input logic [7:0] id);
    logic [31:0] readback;
    apb_transfer(1'b1, {24'h0, id}, readback);
    model_slave_id = id;
    apb_transfer(1'b0, 32'h0, readback);
    if (readback !== {24'h0, model_slave_id}) begin
      log_failure($sformatf("slave_id readback: expected %h, got %h",
                            {24'h0, model_slave_id}, readback));
    end
  endtask

  function automatic void queue_request(input logic [1:0] mode, input logic [7:0] data,
                                        input logic last, input logic [15:0] addr,
                                        input logic [15:0] word);
    framer_req_t r;
    r = '{mode: mode, data: data, last: last, addr: addr, word: word};
    request_q.push_back(r);
    if (mode != MODE_UNUSED) stim_count++;
  endfunction

  // Mostly random, with the extremes showing up often
  function automatic logic [15:0] pick_word();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  // Response frame with a correct CRC: id, function, payload, CRC low, CRC high
  function automatic void build_response(input int payload_len, input logic [7:0] fn);
    logic [15:0] crc;
    frame_bytes.delete();
    frame_bytes.push_back(8'($urandom_range(255)));
    frame_bytes.push_back(fn);
    for (int i = 0; i < payload_len; i++) frame_bytes.push_back(8'($urandom_range(255)));
    crc = CRC_SEED;
    foreach (frame_bytes[i]) crc = crc16_step(crc, frame_bytes[i]);
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
  endfunction

  // Queue the frame bytes, sometimes slipping other requests in between
  function automatic void send_frame(input int interleave_pct);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      queue_request(MODE_RX, frame_bytes[i], i == frame_bytes.size() - 1,
                    pick_word(), pick_word());
      if (i < frame_bytes.size() - 1 && $urandom_range(99) < interleave_pct) begin
        queue_request(2'($urandom_range(3, 1)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), pick_word(), pick_word());
      end
    end
  endfunction

  function automatic void run_random_phase(input int n_items);
    int start;
    int pick;
    int len;
    start = stim_count;
    while (stim_count - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 18) begin
        queue_request($urandom_range(1) ? MODE_READ : MODE_WRITE, 8'($urandom_range(255)),
                      1'($urandom_range(1)), pick_word(), pick_word());
      end else if (pick < 22) begin
        queue_request(MODE_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      pick_word(), pick_word());
      end else if (pick < 85) begin
        // well-formed frame, corrupted by one bit flip now and then
        build_response($urandom_range(6),
                       ($urandom_range(9) != 0) ? FN_READ : 8'($urandom_range(255)));
        if (pick >= 72) begin
          len = $urandom_range(frame_bytes.size() - 1);
          frame_bytes[len] = frame_bytes[len] ^ (8'h01 << $urandom_range(7));
        end
        send_frame(8);
      end else begin
        // noise burst ending a frame
        len = $urandom_range(5, 1);
        for (int i = 0; i < len; i++) begin
          queue_request(MODE_RX, 8'($urandom_range(255)), i == len - 1,
                        pick_word(), pick_word());
        end
      end
    end
  endfunction

  // Idle point: everything sent and checked, then a settling wait
  task automatic wait_drained();
    while (request_q.size() != 0 || tx_verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] readback;
    rst_n             = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_RX;
    in_ch.in_byte     = '0;
    in_ch.in_last     = 1'b0;
    in_ch.reg_address = '0;
    in_ch.word_value  = '0;
    out_ch.ready      = 1'b0;
    model_slave_id    = 8'd1;
    clear_rx_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset value of slave_id
    apb_transfer(1'b0, 32'h0, readback);
    if (readback !== {24'h0, model_slave_id}) begin
      log_failure($sformatf("slave_id after reset: expected %h, got %h",
                            {24'h0, model_slave_id}, readback));
    end

    // Directed: field extremes, ignored mode, requests mid-frame, short frames
    queue_request(MODE_READ, 8'h00, 1'b0, 16'h0000, 16'h0000);
    queue_request(MODE_WRITE, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
    queue_request(MODE_UNUSED, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
    build_response(2, FN_READ);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      queue_request(MODE_RX, frame_bytes[i], i == frame_bytes.size() - 1, 16'h0000, 16'hFFFF);
      if (i == 2) queue_request(MODE_WRITE, 8'h5A, 1'b1, 16'h1234, 16'h0001);
      if (i == 3) queue_request(MODE_UNUSED, 8'hA5, 1'b1, 16'hFFFF, 16'h0000);
    end
    build_response(1, FN_READ_EXCEPTION);
    send_frame(0);
    queue_request(MODE_RX, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
    queue_request(MODE_RX, 8'h00, 1'b0, 16'h0000, 16'h0000);
    queue_request(MODE_RX, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
    queue_request(MODE_RX, 8'h01, 1'b0, 16'h0000, 16'h0000);
    queue_request(MODE_RX, FN_READ, 1'b0, 16'h0000, 16'h0000);
    queue_request(MODE_RX, 8'hFF, 1'b1, 16'h0000, 16'h0000);
    wait_drained();

    // No idling; long result hold-off fills the block; then a frame past the limit
    program_slave_id(8'h00);
    hold_requests++;
    run_random_phase(PHASE_ITEMS);
    build_response(MAX_FRAME - 4, FN_READ);
    frame_bytes.push_back(8'($urandom_range(255)));
    frame_bytes.push_back(8'($urandom_range(255)));
    send_frame(2);
    wait_drained();

    // Sender mostly idle
    program_slave_id(8'hFF);
    send_idle_pct = 84;
    run_random_phase(PHASE_ITEMS);
    wait_drained();

    // Receiver mostly stalled
    program_slave_id(8'($urandom_range(254, 1)));
    send_idle_pct = 0;
    stall_pct     = 84;
    run_random_phase(PHASE_ITEMS);
    wait_drained();

    // Both sides idle at times
    program_slave_id(8'($urandom_range(255)));
    send_idle_pct = 38;
    stall_pct     = 38;
    run_random_phase(PHASE_ITEMS);
    wait_drained();

    if (fail_count == 0) begin
      $display("modbus_rtu_master_framer_test passed");
    end else begin
      $display("modbus_rtu_master_framer_test failed");
    end
    $finish;
  end

endmodule
